/* hdl/sma_pkg.sv */
// Shared types and constants of the stack machine ALU.
`timescale 1ns / 1ps

package sma_pkg;

    localparam int WORD_W  = 32;
    localparam int DEPTH_W = 7;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MOD   = 4'd5,
        OP_EQ    = 4'd6,
        OP_NE    = 4'd7,
        OP_LT    = 4'd8,
        OP_LE    = 4'd9,
        OP_GT    = 4'd10,
        OP_GE    = 4'd11,
        OP_POPW  = 4'd12,
        OP_POPB  = 4'd13
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2,
        STAT_DIVZ  = 2'd3
    } status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* hdl/stack_machine_alu_unit.sv */
// Stack machine execution unit: controller, stack memory and divider.
//
// Usage:
//   Request channel: req_valid / req_stall carry req_type and push_value.
//   Result channel: result_valid / result_stall carry status, out_valid,
//   out_value and stack_depth; every request gives exactly one result.
//   The stack lives in a synchronous memory with a registered read; a
//   sequencer reads the top word, then the next word, computes, and writes
//   the result back over the next word.
//   Push writes from idle; pop passes RD1; add/sub/mul/compare pass RD1,
//   RD2, EXEC and WB; div/mod also wait in DIVW (one quotient bit per
//   cycle in the divider); errors (underflow, overflow, divide by zero)
//   end early. The next request is taken the cycle after a result loads.
//   One request is in work at a time; req_stall is high while it runs.
//   A finished result sits in the output register, and the next request is
//   taken while it waits there; a stalled receiver holds the block only
//   when a second result is ready behind it.
//   Reset empties the stack (depth 0) and drops result_valid; no
//   clearing pass runs over the memory.
`timescale 1ns / 1ps

module stack_machine_alu_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [3:0]                  req_type,
    input  logic signed [31:0]          push_value,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [1:0]                  status,
    output logic                        out_valid,
    output logic signed [31:0]          out_value,
    output logic [sma_pkg::DEPTH_W-1:0] stack_depth
);
    import sma_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RD1  = 7'b0000010,
        ST_RD2  = 7'b0000100,
        ST_EXEC = 7'b0001000,
        ST_DIVW = 7'b0010000,
        ST_WB   = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     sp_reg, sp_next;
    op_t               op_reg, op_next;
    status_t           stat_reg, stat_next;
    logic              popv_reg, popv_next;
    logic [WORD_W-1:0] t_reg, t_next;
    logic [WORD_W-1:0] n_reg, n_next;
    logic [WORD_W-1:0] res_reg, res_next;

    logic               rv_reg;
    status_t            o_stat_reg;
    logic               o_valid_reg;
    logic [WORD_W-1:0]  o_value_reg;
    logic [DEPTH_W-1:0] o_depth_reg;

    op_t               req_op;
    logic [PW-1:0]     sp_m1;
    logic [PW-1:0]     sp_m2;
    logic              out_load;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    logic              div_start;
    div_stat_t         div_stat;
    logic [WORD_W-1:0] div_quo;
    logic [WORD_W-1:0] div_rem;

    assign req_op   = op_t'(req_type);
    assign sp_m1    = sp_reg - 1'b1;
    assign sp_m2    = sp_reg - 2'd2;
    assign out_load = (state_reg == ST_DONE) && (!rv_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        op_next    = op_reg;
        stat_next  = stat_reg;
        popv_next  = popv_reg;
        t_next     = t_reg;
        n_next     = n_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = sp_reg[AW-1:0];
        mem_wdata  = push_value;
        mem_raddr  = sp_m1[AW-1:0];
        div_start  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next   = req_op;
                    stat_next = STAT_OK;
                    popv_next = 1'b0;
                    res_next  = '0;
                    state_next = ST_DONE;
                    unique case (req_op) inside
                        OP_PUSH:
                        begin
                            if (sp_reg == PW'(STACK_DEPTH))
                            begin
                                stat_next = STAT_OVER;
                            end
                            else
                            begin
                                mem_we  = 1'b1;
                                sp_next = sp_reg + 1'b1;
                            end
                        end
                        OP_POPW, OP_POPB:
                        begin
                            if (sp_reg == '0)
                            begin
                                stat_next = STAT_UNDER;
                            end
                            else
                            begin
                                state_next = ST_RD1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ,
                        OP_NE, OP_LT, OP_LE, OP_GT, OP_GE:
                        begin
                            if (sp_reg < PW'(2))
                            begin
                                stat_next = STAT_UNDER;
                            end
                            else
                            begin
                                state_next = ST_RD1;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_RD1:
            begin
                if (op_reg == OP_POPW || op_reg == OP_POPB)
                begin
                    res_next = (op_reg == OP_POPB)
                             ? {{(WORD_W-8){mem_rdata[7]}}, mem_rdata[7:0]}
                             : mem_rdata;
                    popv_next  = 1'b1;
                    sp_next    = sp_m1;
                    state_next = ST_DONE;
                end
                else
                begin
                    // top word arrived; fetch the next one
                    t_next     = mem_rdata;
                    mem_raddr  = sp_m2[AW-1:0];
                    state_next = ST_RD2;
                end
            end
            ST_RD2:
            begin
                n_next = mem_rdata;
                if ((op_reg == OP_DIV || op_reg == OP_MOD) && t_reg == '0)
                begin
                    stat_next  = STAT_DIVZ;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_WB;
                case (op_reg)
                    OP_ADD: res_next = n_reg + t_reg;
                    OP_SUB: res_next = n_reg - t_reg;
                    OP_MUL: res_next = n_reg * t_reg;
                    OP_EQ:  res_next = WORD_W'(n_reg == t_reg);
                    OP_NE:  res_next = WORD_W'(n_reg != t_reg);
                    OP_LT:  res_next = WORD_W'($signed(n_reg) < $signed(t_reg));
                    OP_LE:  res_next = WORD_W'($signed(n_reg) <= $signed(t_reg));
                    OP_GT:  res_next = WORD_W'($signed(n_reg) > $signed(t_reg));
                    OP_GE:  res_next = WORD_W'($signed(n_reg) >= $signed(t_reg));
                    default:
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVW;
                    end
                endcase
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    res_next   = (op_reg == OP_DIV) ? div_quo : div_rem;
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                // result replaces the next-of-top word
                mem_we     = 1'b1;
                mem_waddr  = sp_m2[AW-1:0];
                mem_wdata  = res_reg;
                sp_next    = sp_m1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sp_reg    <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            if (out_load)
            begin
                rv_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                rv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        stat_reg <= stat_next;
        popv_reg <= popv_next;
        t_reg    <= t_next;
        n_reg    <= n_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            o_stat_reg  <= stat_reg;
            o_valid_reg <= popv_reg;
            o_value_reg <= popv_reg ? res_reg : '0;
            o_depth_reg <= DEPTH_W'(sp_reg);
        end
    end

    sma_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sma_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (t_reg),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign req_stall    = (state_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign status       = o_stat_reg;
    assign out_valid    = o_valid_reg;
    assign out_value    = o_value_reg;
    assign stack_depth  = o_depth_reg;

`ifndef SYNTH
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_sp_step: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg == $past(sp_reg) || sp_reg == $past(sp_reg) + 1'b1
        || sp_reg == $past(sp_reg) - 1'b1)
        else $error("stack pointer moved by more than one word");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE || state_reg == ST_WB))
        else $error("stack write outside push or write-back");

    a_rv_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rv_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished request");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVW && !div_stat.busy))
        else $error("divider finished while no division was pending");
`endif

endmodule

/* hdl/sma_stack_ram.sv */
// Stack word memory: one write port, one registered read port.
`timescale 1ns / 1ps

module sma_stack_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [sma_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [sma_pkg::WORD_W-1:0] rdata
);
    import sma_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/sma_div.sv */
// Iterative signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sma_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sma_pkg::WORD_W-1:0] dividend,
    input  logic [sma_pkg::WORD_W-1:0] divisor,
    output sma_pkg::div_stat_t         stat,
    output logic [sma_pkg::WORD_W-1:0] quotient,
    output logic [sma_pkg::WORD_W-1:0] remainder
);
    import sma_pkg::*;

    localparam int CW = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        shifted    = {rem_reg, quo_reg[WORD_W-1]};
        trial      = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            quo_next   = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
            dsr_next   = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
            neg_q_next = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            neg_r_next = dividend[WORD_W-1];
        end
        else if (busy_reg)
        begin
            // keep the partial remainder when the trial subtract goes negative
            if (!trial[WORD_W])
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dsr_reg   <= dsr_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_q_reg ? (WORD_W'(0) - quo_reg) : quo_reg;
    assign remainder = neg_r_reg ? (WORD_W'(0) - rem_reg) : rem_reg;

endmodule
